/* rtl/core/bptc_pkg.sv */
// Package for the barometric pressure and temperature compensation block.
// Holds the field widths, the register indexes and the coefficient bundle type.
// Has no dependencies. Every other file of the block uses it.
package bptc_pkg;

  localparam int unsigned RawW      = 24;
  localparam int unsigned CoeffW    = 16;
  localparam int unsigned TempW     = 19;
  localparam int unsigned PressW    = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PipeDepth = 8;

  // Indexes of the configuration registers.
  localparam logic [CfgIdxW-1:0] CfgSensIdx   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOffIdx    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSensTcIdx = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffTcIdx  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTrefIdx   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTsensIdx  = 3'd5;

  // 20.00 C, the point at which second-order correction starts.
  localparam logic signed [TempW-1:0] TempBase = 19'sd2000;

  typedef struct packed {
    logic [CoeffW-1:0] sens;
    logic [CoeffW-1:0] off;
    logic [CoeffW-1:0] sens_tc;
    logic [CoeffW-1:0] off_tc;
    logic [CoeffW-1:0] tref;
    logic [CoeffW-1:0] tsens;
  } coeff_t;

endpackage

/* rtl/core/bptc_if.sv */
// Valid/ready channel interfaces for the raw reading pair and the result.
// Depends on bptc_pkg for the field widths.
interface bptc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bptc_pkg::RawW-1:0]     press_code;
  logic [bptc_pkg::RawW-1:0]     temp_code;

  modport source (output valid, press_code, temp_code, input ready);
  modport sink   (input valid, press_code, temp_code, output ready);
endinterface

interface bptc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bptc_pkg::TempW-1:0]  temp_centi;
  logic signed [bptc_pkg::PressW-1:0] pressure_centi;

  modport source (output valid, temp_centi, pressure_centi, input ready);
  modport sink   (input valid, temp_centi, pressure_centi, output ready);
endinterface

/* rtl/core/bptc_datapath.sv */
// Eight-stage compensation pipeline: temperature, second-order terms, offset,
// sensitivity and pressure. Depends on bptc_pkg. All stages move together on en_i.
module bptc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [bptc_pkg::RawW-1:0]           press_code_i,
  input  logic [bptc_pkg::RawW-1:0]           temp_code_i,
  input  bptc_pkg::coeff_t                    coeff_i,
  output logic                                valid_o,
  output logic signed [bptc_pkg::TempW-1:0]   temp_centi_o,
  output logic signed [bptc_pkg::PressW-1:0]  pressure_centi_o
);

  logic [bptc_pkg::PipeDepth-1:0] valid_q;

  // Stage 1: dT.
  logic [23:0]        d1_1_q;
  logic signed [24:0] dt_d, dt_1_q;
  // Stage 2: the four products of dT.
  logic [23:0]        d1_2_q;
  logic signed [41:0] dt_ext;
  logic signed [41:0] pt_d, po_d, ps_d, pt_2_q, po_2_q, ps_2_q;
  logic signed [49:0] dt_wide, dtsq_d;
  logic [47:0]        dtsq_2_q;
  // Stage 3: first-order temperature, T2, offset and sensitivity bases.
  logic [23:0]        d1_3_q;
  logic signed [17:0] q_3_q;
  logic [16:0]        t2_3_q;
  logic signed [39:0] offb_d, sensb_d, offb_3_q, sensb_3_q;
  // Stage 4: square of the temperature deviation, final temperature.
  logic [23:0]        d1_4_q;
  logic               neg_4_q;
  logic signed [35:0] sq_d;
  logic [34:0]        sq_4_q;
  logic signed [18:0] temp_d, temp_4_q;
  logic signed [39:0] offb_4_q, sensb_4_q;
  // Stage 5: OFF and SENS with second-order terms applied.
  logic [23:0]        d1_5_q;
  logic [36:0]        sq5;
  logic signed [39:0] off_d, sens_d, off_5_q, sens_5_q;
  logic signed [18:0] temp_5_q;
  // Stage 6: partial products of D1 * SENS.
  logic [43:0]        plo_d, plo_6_q;
  logic signed [44:0] phi_d, phi_6_q;
  logic signed [39:0] off_6_q;
  logic signed [18:0] temp_6_q;
  // Stage 7: full product.
  logic signed [63:0] prod_d, prod_7_q;
  logic signed [39:0] off_7_q;
  logic signed [18:0] temp_7_q;
  // Stage 8: pressure.
  logic signed [47:0] diff;
  logic signed [31:0] p_8_q;
  logic signed [18:0] temp_8_q;

  always_comb begin
    dt_d = $signed({1'b0, temp_code_i}) - $signed({1'b0, coeff_i.tref, 8'd0});
  end

  always_comb begin
    dt_ext  = {{17{dt_1_q[24]}}, dt_1_q};
    dt_wide = {{25{dt_1_q[24]}}, dt_1_q};
    pt_d    = dt_ext * $signed({26'd0, coeff_i.tsens});
    po_d    = dt_ext * $signed({26'd0, coeff_i.off_tc});
    ps_d    = dt_ext * $signed({26'd0, coeff_i.sens_tc});
    dtsq_d  = dt_wide * dt_wide;
  end

  // The arithmetic shifts are taken as part-selects of sign-extended products.
  always_comb begin
    offb_d  = $signed({8'd0, coeff_i.off, 16'd0}) + $signed({{5{po_2_q[41]}}, po_2_q[41:7]});
    sensb_d = $signed({9'd0, coeff_i.sens, 15'd0})
            + $signed({{6{ps_2_q[41]}}, ps_2_q[41:8]});
  end

  // TEMP < 2000 exactly when the scaled dT*C6 term is negative.
  always_comb begin
    sq_d   = $signed({{18{q_3_q[17]}}, q_3_q}) * $signed({{18{q_3_q[17]}}, q_3_q});
    temp_d = bptc_pkg::TempBase + $signed({q_3_q[17], q_3_q})
           - (q_3_q[17] ? $signed({2'b00, t2_3_q}) : 19'sd0);
  end

  always_comb begin
    sq5    = {2'b00, sq_4_q} + {sq_4_q, 2'b00};
    off_d  = offb_4_q  - (neg_4_q ? $signed({4'd0, sq5[36:1]}) : 40'sd0);
    sens_d = sensb_4_q - (neg_4_q ? $signed({5'd0, sq5[36:2]}) : 40'sd0);
  end

  always_comb begin
    plo_d = {20'd0, d1_5_q} * {24'd0, sens_5_q[19:0]};
    phi_d = $signed({{21{1'b0}}, d1_5_q}) * $signed({{25{sens_5_q[39]}}, sens_5_q[39:20]});
  end

  always_comb begin
    prod_d = $signed({phi_6_q[43:0], 20'd0}) + $signed({20'd0, plo_6_q});
  end

  always_comb begin
    diff = $signed({{5{prod_7_q[63]}}, prod_7_q[63:21]}) - $signed({{8{off_7_q[39]}}, off_7_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[bptc_pkg::PipeDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_1_q    <= press_code_i;
      dt_1_q    <= dt_d;

      d1_2_q    <= d1_1_q;
      pt_2_q    <= pt_d;
      po_2_q    <= po_d;
      ps_2_q    <= ps_d;
      dtsq_2_q  <= dtsq_d[47:0];

      d1_3_q    <= d1_2_q;
      q_3_q     <= pt_2_q[40:23];
      t2_3_q    <= dtsq_2_q[47:31];
      offb_3_q  <= offb_d;
      sensb_3_q <= sensb_d;

      d1_4_q    <= d1_3_q;
      neg_4_q   <= q_3_q[17];
      sq_4_q    <= sq_d[34:0];
      temp_4_q  <= temp_d;
      offb_4_q  <= offb_3_q;
      sensb_4_q <= sensb_3_q;

      d1_5_q    <= d1_4_q;
      off_5_q   <= off_d;
      sens_5_q  <= sens_d;
      temp_5_q  <= temp_4_q;

      plo_6_q   <= plo_d;
      phi_6_q   <= phi_d;
      off_6_q   <= off_5_q;
      temp_6_q  <= temp_5_q;

      prod_7_q  <= prod_d;
      off_7_q   <= off_6_q;
      temp_7_q  <= temp_6_q;

      p_8_q     <= diff[46:15];
      temp_8_q  <= temp_7_q;
    end
  end

  assign valid_o          = valid_q[bptc_pkg::PipeDepth-1];
  assign temp_centi_o     = temp_8_q;
  assign pressure_centi_o = p_8_q;

endmodule

/* rtl/core/baro_pressure_temp_compensation.sv */
// Barometric pressure and temperature compensation. Each transfer on in_i carries
// one raw pressure and temperature pair; after the eight-stage pipeline, one out_o
// transfer carries temperature in centidegrees C and pressure in hundredths of mbar
// (wrapping at 32 bits), with second-order correction below 20.00 C. One pair is
// taken per cycle; the pipeline holds as a whole while out_o is stalled. The user
// must write the six calibration words on the cfg port only while idle; the block
// itself does not enforce it. Depends on bptc_pkg, bptc_if and bptc_datapath.
module baro_pressure_temp_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [bptc_pkg::CoeffW-1:0]         cfg_wdata_i,
  bptc_in_if.sink                             in_i,
  bptc_out_if.source                          out_o
);

  bptc_pkg::coeff_t coeff_q;
  logic             advance;
  logic             dp_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bptc_pkg::CfgSensIdx:   coeff_q.sens    <= cfg_wdata_i;
        bptc_pkg::CfgOffIdx:    coeff_q.off     <= cfg_wdata_i;
        bptc_pkg::CfgSensTcIdx: coeff_q.sens_tc <= cfg_wdata_i;
        bptc_pkg::CfgOffTcIdx:  coeff_q.off_tc  <= cfg_wdata_i;
        bptc_pkg::CfgTrefIdx:   coeff_q.tref    <= cfg_wdata_i;
        bptc_pkg::CfgTsensIdx:  coeff_q.tsens   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever its last stage is empty or being transferred out.
  assign advance  = !dp_valid || out_o.ready;
  assign in_i.ready = advance;

  bptc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .valid_i          (in_i.valid),
    .press_code_i     (in_i.press_code),
    .temp_code_i      (in_i.temp_code),
    .coeff_i          (coeff_q),
    .valid_o          (dp_valid),
    .temp_centi_o     (out_o.temp_centi),
    .pressure_centi_o (out_o.pressure_centi)
  );

  assign out_o.valid = dp_valid;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for baro_pressure_temp_compensation: drives raw reading pairs,
// predicts the compensated temperature and pressure, and checks every result transfer.
// Depends on bptc_pkg, bptc_if and the block's RTL.
module testbench;

  localparam int unsigned ClkHalf        = 10;
  localparam int unsigned ResetCycles    = 5;
  localparam int unsigned SinkHoldCycles = 400;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned RawW           = bptc_pkg::RawW;
  localparam int unsigned CoeffW         = bptc_pkg::CoeffW;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [bptc_pkg::CfgIdxW-1:0] CfgUnusedLoIdx = 3'd6;
  localparam logic [bptc_pkg::CfgIdxW-1:0] CfgUnusedHiIdx = 3'd7;

  localparam logic [RawW-1:0] RawMax = '1;

  typedef struct packed {
    logic signed [bptc_pkg::TempW-1:0]  temp_centi;
    logic signed [bptc_pkg::PressW-1:0] pressure_centi;
  } reading_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [bptc_pkg::CfgIdxW-1:0]    cfg_index_i;
  logic [CoeffW-1:0]               cfg_wdata_i;

  bptc_in_if  in_if ();
  bptc_out_if out_if ();

  baro_pressure_temp_compensation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  bptc_pkg::coeff_t cal_words;
  reading_result_t  results_pending[$];
  int unsigned      mismatch_count = 0;
  int unsigned      quiet_cycles = 0;
  bit               send_idle_en = 1'b1;
  bit               sink_stall_en = 1'b1;
  bit               hold_pending = 1'b0;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // First- and second-order compensation at 64 bits; >>> on longint rounds toward
  // minus infinity, as the scheme requires.
  function automatic reading_result_t compensate_reading(input logic [RawW-1:0] d1_raw,
                                                         input logic [RawW-1:0] d2_raw);
    reading_result_t r;
    longint d1, dt, temp, t2, off2, sens2, off, sens, p, d, sq5, t_final;
    d1    = longint'(d1_raw);
    dt    = longint'(d2_raw) - (longint'(cal_words.tref) << 8);
    temp  = 2000 + ((dt * longint'(cal_words.tsens)) >>> 23);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < 2000) begin
      d     = temp - 2000;
      sq5   = d * d * 5;
      t2    = (dt * dt) >>> 31;
      off2  = sq5 >>> 1;
      sens2 = sq5 >>> 2;
    end
    off  = (longint'(cal_words.off) << 16) + ((longint'(cal_words.off_tc) * dt) >>> 7) - off2;
    sens = (longint'(cal_words.sens) << 15) + ((longint'(cal_words.sens_tc) * dt) >>> 8)
           - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    t_final = temp - t2;
    r.temp_centi     = t_final[bptc_pkg::TempW-1:0];
    r.pressure_centi = p[bptc_pkg::PressW-1:0];
    return r;
  endfunction

  function automatic logic [CoeffW-1:0] pick_coeff();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CoeffW'($urandom());
    endcase
  endfunction

  // Leaves cfg_we_i high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [bptc_pkg::CfgIdxW-1:0] idx,
                           input logic [CoeffW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      bptc_pkg::CfgSensIdx:   cal_words.sens    = value;
      bptc_pkg::CfgOffIdx:    cal_words.off     = value;
      bptc_pkg::CfgSensTcIdx: cal_words.sens_tc = value;
      bptc_pkg::CfgOffTcIdx:  cal_words.off_tc  = value;
      bptc_pkg::CfgTrefIdx:   cal_words.tref    = value;
      bptc_pkg::CfgTsensIdx:  cal_words.tsens   = value;
      default: ;
    endcase
  endtask

  task automatic load_coeffs(input bptc_pkg::coeff_t c);
    write_reg(bptc_pkg::CfgSensIdx, c.sens);
    write_reg(bptc_pkg::CfgOffIdx, c.off);
    write_reg(bptc_pkg::CfgSensTcIdx, c.sens_tc);
    write_reg(bptc_pkg::CfgOffTcIdx, c.off_tc);
    write_reg(bptc_pkg::CfgTrefIdx, c.tref);
    write_reg(bptc_pkg::CfgTsensIdx, c.tsens);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one reading pair and returns in the step of its transfer, valid still high.
  task automatic send_reading(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    while (send_idle_en && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.press_code <= d1;
    in_if.temp_code  <= d2;
    do @(posedge clk_i); while (!in_if.ready);
    results_pending.push_back(compensate_reading(d1, d2));
  endtask

  // Lowers valid and waits until every expected result has been transferred.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_readings(input int unsigned count);
    logic [RawW-1:0] d1, d2;
    int              base;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(19))
        0:       d1 = '0;
        1:       d1 = RawMax;
        default: d1 = RawW'($urandom());
      endcase
      base = int'(cal_words.tref) << 8;
      // A third lands close to 20.00 C, where the second-order branch switches.
      case ($urandom_range(2))
        0:       d2 = RawW'($urandom());
        1:       d2 = RawW'(base + $urandom_range(8192) - 4096);
        default: d2 = RawW'(base + $urandom_range(1 << 21) - (1 << 20));
      endcase
      send_reading(d1, d2);
    end
  endtask

  task automatic test_reset_coefficients();
    // All coefficients are zero out of reset.
    send_reading(24'd9085466, 24'd8569150);
    send_reading('0, '0);
    send_reading(RawMax, RawMax);
    send_reading(RawMax, '0);
    drain_results();
  endtask

  task automatic test_directed_corners();
    bptc_pkg::coeff_t typical;
    logic [RawW-1:0]  t_ref;
    typical = '{sens: 16'd40127, off: 16'd36924, sens_tc: 16'd23317,
                off_tc: 16'd23282, tref: 16'd33464, tsens: 16'd28312};
    load_coeffs(typical);
    t_ref = RawW'({cal_words.tref, 8'h00});
    send_reading(24'd9085466, 24'd8569150);
    send_reading('0, '0);
    send_reading(RawMax, '0);
    send_reading('0, RawMax);
    send_reading(RawMax, RawMax);
    send_reading(24'd9085466, t_ref);
    send_reading(24'd9085466, t_ref - 1'b1);
    send_reading(24'd9085466, t_ref + 1'b1);
    // Far below -15.00 C; no third-order term is applied there.
    send_reading(24'd9085466, 24'd3000000);
    send_reading(24'h555555, 24'hAAAAAA);
    send_reading(24'hAAAAAA, 24'h555555);
    drain_results();
    write_reg(CfgUnusedLoIdx, 16'hA5A5);
    write_reg(CfgUnusedHiIdx, 16'h5A5A);
    cfg_we_i <= 1'b0;
    send_reading(24'd9085466, 24'd8569150);
    send_reading(RawMax, t_ref - 1'b1);
    drain_results();
  endtask

  task automatic test_coefficient_extremes();
    load_coeffs('1);
    send_reading(RawMax, '0);
    send_reading(RawMax, RawMax);
    send_random_readings(120);
    drain_results();
    load_coeffs('0);
    send_random_readings(60);
    drain_results();
  endtask

  task automatic test_random_readings();
    bptc_pkg::coeff_t c;
    repeat (5) begin
      c = '{sens: pick_coeff(), off: pick_coeff(), sens_tc: pick_coeff(),
            off_tc: pick_coeff(), tref: pick_coeff(), tsens: pick_coeff()};
      load_coeffs(c);
      send_random_readings(150);
      drain_results();
    end
  endtask

  task automatic test_back_to_back();
    send_idle_en  = 1'b0;
    sink_stall_en = 1'b0;
    send_random_readings(300);
    drain_results();
    send_idle_en  = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  task automatic test_output_hold_off();
    // The sink holds ready low while items keep coming, so the pipeline fills and
    // in_i stalls; then the sender waits for all results before going on.
    hold_pending = 1'b1;
    send_idle_en = 1'b0;
    send_random_readings(60);
    drain_results();
    send_idle_en = 1'b1;
    send_random_readings(40);
    drain_results();
  endtask

  // Result sink: random stalls, plus one long hold-off counted here.
  initial begin : result_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (SinkHoldCycles - 1) @(posedge clk_i);
      end else if (sink_stall_en && $urandom_range(99) < 20) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    reading_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_pending.size() == 0) begin
        $error("result transfer with no reading pending: temp_centi %0d, pressure_centi %0d",
               out_if.temp_centi, out_if.pressure_centi);
        mismatch_count++;
      end else begin
        want = results_pending.pop_front();
        if (out_if.temp_centi !== want.temp_centi) begin
          $error("temp_centi: expected %0d, actual %0d",
                 $signed(want.temp_centi), out_if.temp_centi);
          mismatch_count++;
        end
        if (out_if.pressure_centi !== want.pressure_centi) begin
          $error("pressure_centi: expected %0d, actual %0d",
                 $signed(want.pressure_centi), out_if.pressure_centi);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $error("no transfer for %0d cycles", WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= bptc_pkg::CfgSensIdx;
    cfg_wdata_i      <= '0;
    in_if.valid      <= 1'b0;
    in_if.press_code <= '0;
    in_if.temp_code  <= '0;
    cal_words = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_coefficients();
    test_directed_corners();
    test_coefficient_extremes();
    test_random_readings();
    test_back_to_back();
    test_output_hold_off();

    drain_results();
    repeat (bptc_pkg::PipeDepth + 4) @(posedge clk_i);
    if (results_pending.size() != 0) begin
      $error("%0d expected results never arrived", results_pending.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
